@@ src/mpt_pkg.sv @@
package mpt_pkg;

  localparam int BYTE_W  = 8;
  localparam int SIZE_W  = 13;
  localparam int PROTO_W = 2;
  localparam int INDEX_W = 2;
  localparam int DELTA_W = 10;
  localparam int BTN_W   = 3;

  localparam logic [PROTO_W-1:0] PROTO_PS2    = 2'd0;
  localparam logic [PROTO_W-1:0] PROTO_WHEEL  = 2'd1;
  localparam logic [PROTO_W-1:0] PROTO_SERIAL = 2'd2;

  localparam logic [INDEX_W-1:0] CFG_PROTOCOL = 2'd0;
  localparam logic [INDEX_W-1:0] CFG_WIDTH    = 2'd1;
  localparam logic [INDEX_W-1:0] CFG_HEIGHT   = 2'd2;

  localparam logic [PROTO_W-1:0] RESET_PROTOCOL = PROTO_PS2;
  localparam logic [SIZE_W-1:0]  RESET_WIDTH    = 13'd640;
  localparam logic [SIZE_W-1:0]  RESET_HEIGHT   = 13'd480;

  localparam logic signed [DELTA_W-1:0] BOOST_THRESHOLD = 10'sd5;

  typedef struct packed {
    logic                 we;
    logic [INDEX_W-1:0]   index;
    logic [SIZE_W-1:0]    data;
  } cfg_write_t;

  typedef struct packed {
    logic [BTN_W-1:0]   buttons;
    logic [DELTA_W-1:0] dx;
    logic [DELTA_W-1:0] dy;
  } motion_t;

  typedef struct packed {
    logic    valid;
    motion_t entry;
  } motion_req_t;

endpackage

@@ src/mouse_packet_pointer_tracker.sv @@
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] rx_byte
// m_axis    out        tdata: pointer_x, pointer_y, buttons, zero fill
// cfg       in         cfg_index 0 protocol, 1 screen_width, 2 screen_height
//
// One byte is taken per cycle while the input is not stalled; a finished
// packet is written into a two-entry queue as its last byte is transferred,
// and is loaded from there into the output register.
// Reset is synchronous and leaves the pointer at the screen center.
// The input stalls only while the queue is full behind a stalled output.
module mouse_packet_pointer_tracker #(
  parameter int COORD_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [mpt_pkg::INDEX_W-1:0]           cfg_index,
  input  logic [mpt_pkg::SIZE_W-1:0]            cfg_data,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // rx_byte
  input  logic [mpt_pkg::BYTE_W-1:0]            s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // pointer_x, pointer_y, buttons, from the lowest bit up
  output logic [((2*COORD_BITS+3+7)/8)*8-1:0]   m_tdata
);
  import mpt_pkg::*;

  localparam int OUT_W = ((2 * COORD_BITS + 3 + 7) / 8) * 8;

  cfg_write_t   cfg;
  motion_req_t  q_push;
  motion_req_t  q_head;
  logic         q_full;
  logic         q_pop;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  mpt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tdata    (s_tdata),
    .queue_full (q_full),
    .s_tready   (s_tready),
    .push       (q_push)
  );

  mpt_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .pop  (q_pop),
    .full (q_full),
    .head (q_head)
  );

  mpt_back #(
    .COORD_BITS (COORD_BITS),
    .OUT_W      (OUT_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (q_head),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef NO_ASSERTIONS
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    q_push.valid |-> !q_full)
    else $error("packet pushed into a full queue");

  a_pop_loads_output: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> m_tvalid)
    else $error("popped packet did not reach the output register");

  a_output_drains: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !q_head.valid) |=> !m_tvalid)
    else $error("output stayed valid after its transfer with nothing queued");
`endif

endmodule

@@ src/mpt_front.sv @@
module mpt_front (
  input  logic                        clk,
  input  logic                        rst,
  input  mpt_pkg::cfg_write_t         cfg,
  input  logic                        s_tvalid,
  input  logic [mpt_pkg::BYTE_W-1:0]  s_tdata,
  input  logic                        queue_full,
  output logic                        s_tready,
  output mpt_pkg::motion_req_t        push
);
  import mpt_pkg::*;

  logic [PROTO_W-1:0]  protocol;
  logic [2:0]          byte_count;
  logic [BYTE_W-1:0]   packet_bytes [3];

  logic                accept;
  logic                complete;
  logic                valid;
  logic [BYTE_W-1:0]   b0, b1, b2;
  logic [BTN_W-1:0]    btn;
  logic [DELTA_W-1:0]  dx, dy;
  logic [BYTE_W-1:0]   ser_x, ser_y;
  logic                big;

  assign s_tready = !queue_full;
  assign accept   = s_tvalid && s_tready;
  assign complete = (protocol == PROTO_WHEEL) ? (byte_count == 3'd3) : (byte_count == 3'd2);

  assign b0 = packet_bytes[0];
  assign b1 = packet_bytes[1];
  assign b2 = (byte_count == 3'd2) ? s_tdata : packet_bytes[2];

  assign ser_x = {b0[1:0], b1[5:0]};
  assign ser_y = {b0[3:2], b2[5:0]};

  always_comb begin
    btn   = '0;
    dx    = '0;
    dy    = '0;
    valid = 1'b0;
    unique case (protocol) inside
      PROTO_PS2, PROTO_WHEEL: begin
        btn   = b0[2:0];
        dx    = {{2{b0[4]}}, b1};
        dy    = {{2{b0[5]}}, b2};
        valid = (protocol == PROTO_WHEEL) || (b0[7:6] == 2'b00);
      end
      PROTO_SERIAL: begin
        btn   = {1'b0, b0[4], b0[5]};
        dx    = {{2{ser_x[7]}}, ser_x};
        dy    = DELTA_W'(-$signed({{2{ser_y[7]}}, ser_y}));
        valid = 1'b1;
      end
      default: begin
        valid = 1'b0;
      end
    endcase
  end

  assign big = ($signed(dx) > BOOST_THRESHOLD) || ($signed(dx) < -BOOST_THRESHOLD) ||
               ($signed(dy) > BOOST_THRESHOLD) || ($signed(dy) < -BOOST_THRESHOLD);

  always_comb begin
    push.valid         = accept && complete && valid;
    push.entry.buttons = btn;
    push.entry.dx      = big ? {dx[DELTA_W-2:0], 1'b0} : dx;
    push.entry.dy      = big ? {dy[DELTA_W-2:0], 1'b0} : dy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol   <= RESET_PROTOCOL;
      byte_count <= '0;
    end else if (cfg.we && cfg.index <= CFG_HEIGHT) begin
      if (cfg.index == CFG_PROTOCOL) begin
        protocol <= cfg.data[PROTO_W-1:0];
      end
      byte_count <= '0;
    end else if (accept) begin
      byte_count <= complete ? 3'd0 : byte_count + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_count < 3'd3) begin
      packet_bytes[byte_count[1:0]] <= s_tdata;
    end
  end

endmodule

@@ src/mpt_queue.sv @@
module mpt_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  mpt_pkg::motion_req_t  push,
  input  logic                  pop,
  output logic                  full,
  output mpt_pkg::motion_req_t  head
);
  import mpt_pkg::*;

  motion_t     slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign full       = (count == 2'd2);
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

endmodule

@@ src/mpt_back.sv @@
module mpt_back #(
  parameter int COORD_BITS = 12,
  parameter int OUT_W      = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mpt_pkg::cfg_write_t   cfg,
  input  mpt_pkg::motion_req_t  head,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata
);
  import mpt_pkg::*;

  localparam int SZW  = (COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 1 : SIZE_W;
  localparam int SUMW = (COORD_BITS + 2 > DELTA_W + 1) ? COORD_BITS + 2 : DELTA_W + 1;
  localparam logic [SZW-1:0] FULL_SIZE = SZW'(1) << COORD_BITS;

  function automatic logic [COORD_BITS-1:0] limit_of(input logic [SIZE_W-1:0] size);
    logic [SZW-1:0] s;
    s = SZW'(size);
    if (s == '0) begin
      s = SZW'(1);
    end
    if (s > FULL_SIZE) begin
      s = FULL_SIZE;
    end
    s = s - SZW'(1);
    return s[COORD_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] center_of(input logic [SIZE_W-1:0] size);
    logic [SZW-1:0]        c;
    logic [COORD_BITS-1:0] hi;
    hi = limit_of(size);
    c  = SZW'(size) >> 1;
    if (c > SZW'(hi)) begin
      return hi;
    end
    return c[COORD_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SUMW-1:0] v,
                                                  input logic [COORD_BITS-1:0] hi);
    if (v < 0) begin
      return '0;
    end
    if (v > $signed(SUMW'(hi))) begin
      return hi;
    end
    return v[COORD_BITS-1:0];
  endfunction

  logic [SIZE_W-1:0]       screen_width;
  logic [SIZE_W-1:0]       screen_height;
  logic [COORD_BITS-1:0]   pos_x;
  logic [COORD_BITS-1:0]   pos_y;
  logic [SIZE_W-1:0]       width_next;
  logic [SIZE_W-1:0]       height_next;
  logic [COORD_BITS-1:0]   pos_x_next;
  logic [COORD_BITS-1:0]   pos_y_next;
  logic signed [SUMW-1:0]  sum_x;
  logic signed [SUMW-1:0]  sum_y;
  logic                    cfg_hit;

  assign pop     = head.valid && (!m_tvalid || m_tready);
  assign cfg_hit = cfg.we && (cfg.index <= CFG_HEIGHT);

  assign width_next  = (cfg.index == CFG_WIDTH)  ? cfg.data : screen_width;
  assign height_next = (cfg.index == CFG_HEIGHT) ? cfg.data : screen_height;

  assign sum_x = $signed(SUMW'(pos_x)) + SUMW'($signed(head.entry.dx));
  assign sum_y = $signed(SUMW'(pos_y)) - SUMW'($signed(head.entry.dy));
  assign pos_x_next = clamp(sum_x, limit_of(screen_width));
  assign pos_y_next = clamp(sum_y, limit_of(screen_height));

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RESET_WIDTH;
      screen_height <= RESET_HEIGHT;
      pos_x         <= center_of(RESET_WIDTH);
      pos_y         <= center_of(RESET_HEIGHT);
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_hit) begin
        screen_width  <= width_next;
        screen_height <= height_next;
        pos_x         <= center_of(width_next);
        pos_y         <= center_of(height_next);
      end else if (pop) begin
        pos_x <= pos_x_next;
        pos_y <= pos_y_next;
      end
      if (pop) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= OUT_W'({head.entry.buttons, pos_y_next, pos_x_next});
    end
  end

endmodule
